FILE: rtl/bba_pkg.sv
package bba_pkg;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_A_WANT,
        S_A_SCAN,
        S_A_ORD,
        S_A_SPLIT,
        S_A_SPL2,
        S_A_PUSHQ,
        S_A_UNL,
        S_F_CHK,
        S_F_BSY,
        S_F_LOOP,
        S_F_BUD,
        S_F_MRG,
        S_F_DONE,
        S_U0,
        S_U1,
        S_P0,
        S_P1,
        S_P2
    } t_state;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_MEM  = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;

endpackage

FILE: rtl/bba_ram.sv
module bba_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/buddy_block_allocator_top.sv
// One command at a time: busy is high from accept until the result strobe.
// Each result is on the ports for one cycle with o_valid; the receiver cannot stall.
// Synchronous reset, then a clearing pass over the unit order and busy memories
//   with busy high.
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int POOL_ORDER   = 16,
    parameter int MIN_ORDER    = 5,
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_block_address,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_address,
    output logic [4:0]  o_result_order
);

    localparam int TOP    = (POOL_ORDER > MIN_ORDER) ? POOL_ORDER : MIN_ORDER;
    localparam int UBITS  = TOP - MIN_ORDER;
    localparam int UNITS  = 1 << UBITS;
    localparam int NLISTS = UBITS + 1;
    localparam int UW     = (UBITS > 0) ? UBITS : 1;
    localparam int LW     = ($clog2(NLISTS) > 0) ? $clog2(NLISTS) : 1;
    localparam logic [UW-1:0] UMASK = UW'(UNITS - 1);

    function automatic logic [LW-1:0] f_list(input logic [4:0] o);
        logic [4:0] li;
        li = (o >= 5'(MIN_ORDER)) ? o - 5'(MIN_ORDER) : 5'd0;
        return (li < 5'(NLISTS)) ? li[LW-1:0] : LW'(NLISTS - 1);
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    logic [UW-1:0] r_clr, n_clr;
    logic [15:0]   r_req, n_req, r_addr, n_addr;
    logic [4:0]    r_want, n_want, r_i, n_i, r_ord, n_ord;
    logic [LW-1:0] r_li, n_li;
    logic [UW-1:0] r_p, n_p, r_q, n_q, r_u, n_u, r_b, n_b, r_x, n_x;
    logic [UW-1:0] r_h, n_h, r_bk, n_bk;
    logic          r_vld [NLISTS];
    logic          n_vld [NLISTS];
    logic [UW-1:0] r_head [NLISTS];
    logic [UW-1:0] n_head [NLISTS];
    logic          r_valid, n_valid;
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_raddr_out, n_raddr_out;
    logic [4:0]    r_rorder, n_rorder;

    logic          ord_we, bsy_we, nxt_we, prv_we, bsy_wd, bsy_q;
    logic [UW-1:0] ord_wa, bsy_wa, nxt_wa, prv_wa, nxt_wd, prv_wd;
    logic [UW-1:0] ou_ra, nxt_ra, prv_ra, nxt_q, prv_q;
    logic [4:0]    ord_wd, ord_q;

    bba_ram #(.W(5), .DEPTH(UNITS), .AW(UW)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_wa), .i_wdata(ord_wd),
        .i_raddr(ou_ra), .o_rdata(ord_q));
    bba_ram #(.W(1), .DEPTH(UNITS), .AW(UW)) u_bsy (
        .i_clk(i_clk), .i_we(bsy_we), .i_waddr(bsy_wa), .i_wdata(bsy_wd),
        .i_raddr(ou_ra), .o_rdata(bsy_q));
    bba_ram #(.W(UW), .DEPTH(UNITS), .AW(UW)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_q));
    bba_ram #(.W(UW), .DEPTH(UNITS), .AW(UW)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(prv_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
            r_clr   <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < NLISTS; k++) begin
                r_vld[k]  <= (k == NLISTS - 1);
                r_head[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            for (int k = 0; k < NLISTS; k++) begin
                r_vld[k]  <= n_vld[k];
                r_head[k] <= n_head[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_addr      <= n_addr;
        r_want      <= n_want;
        r_i         <= n_i;
        r_ord       <= n_ord;
        r_li        <= n_li;
        r_p         <= n_p;
        r_q         <= n_q;
        r_u         <= n_u;
        r_b         <= n_b;
        r_x         <= n_x;
        r_h         <= n_h;
        r_bk        <= n_bk;
        r_status    <= n_status;
        r_raddr_out <= n_raddr_out;
        r_rorder    <= n_rorder;
    end

    always_comb begin
        logic [16:0]   nb;
        logic [31:0]   u32;
        logic [4:0]    half;
        logic [UW-1:0] tmp;

        n_state = r_state;   n_ret = r_ret;   n_clr = r_clr;
        n_req = r_req;       n_addr = r_addr; n_want = r_want; n_i = r_i;
        n_ord = r_ord;       n_li = r_li;     n_p = r_p;       n_q = r_q;
        n_u = r_u;           n_b = r_b;       n_x = r_x;       n_h = r_h;
        n_bk = r_bk;
        n_valid = 1'b0;
        n_status = r_status; n_raddr_out = r_raddr_out; n_rorder = r_rorder;
        for (int k = 0; k < NLISTS; k++) begin
            n_vld[k]  = r_vld[k];
            n_head[k] = r_head[k];
        end
        ord_we = 1'b0; ord_wa = r_p; ord_wd = r_ord;
        bsy_we = 1'b0; bsy_wa = r_p; bsy_wd = 1'b0;
        nxt_we = 1'b0; nxt_wa = r_x; nxt_wd = r_x;
        prv_we = 1'b0; prv_wa = r_x; prv_wd = r_x;
        ou_ra = r_u; nxt_ra = r_x; prv_ra = r_x;
        nb   = 17'(r_req) + 17'(HEADER_BYTES);
        u32  = 32'(r_addr) >> MIN_ORDER;
        half = r_ord - 5'd1;
        tmp  = '0;

        case (r_state)
            S_CLR: begin
                ord_we = 1'b1; ord_wa = r_clr;
                ord_wd = (r_clr == '0) ? 5'(TOP) : 5'd0;
                bsy_we = 1'b1; bsy_wa = r_clr; bsy_wd = 1'b0;
                nxt_we = 1'b1; nxt_wa = '0; nxt_wd = '0;
                prv_we = 1'b1; prv_wa = '0; prv_wd = '0;
                n_clr = (r_clr + UW'(1)) & UMASK;
                if (r_clr == UMASK) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req  = i_request_bytes;
                    n_addr = i_block_address;
                    n_want = 5'(MIN_ORDER);
                    n_state = (i_command == CMD_ALLOC) ? S_A_WANT : S_F_CHK;
                end
            end
            S_A_WANT: begin
                if (r_want < 5'd17 && (17'd1 << r_want) < nb) begin
                    n_want = r_want + 5'd1;
                end else if (r_want > 5'(TOP)) begin
                    n_status = ST_NO_MEM; n_raddr_out = '0; n_rorder = '0;
                    n_valid = 1'b1; n_state = S_IDLE;
                end else begin
                    n_i = r_want - 5'(MIN_ORDER);
                    n_state = S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                if (r_i >= 5'(NLISTS)) begin
                    n_status = ST_NO_MEM; n_raddr_out = '0; n_rorder = '0;
                    n_valid = 1'b1; n_state = S_IDLE;
                end else if (r_vld[r_i[LW-1:0]]) begin
                    n_p = r_head[r_i[LW-1:0]] & UMASK;
                    ou_ra = r_head[r_i[LW-1:0]] & UMASK;
                    n_state = S_A_ORD;
                end else begin
                    n_i = r_i + 5'd1;
                end
            end
            S_A_ORD: begin
                n_ord = ord_q; n_li = f_list(ord_q);
                n_x = r_p; n_ret = S_A_SPLIT; n_state = S_U0;
            end
            S_A_SPLIT: begin
                if (r_ord > r_want) begin
                    n_q = UW'(32'(r_p) + (32'd1 << (half - 5'(MIN_ORDER)))) & UMASK;
                    ord_we = 1'b1; ord_wa = r_p; ord_wd = half;
                    bsy_we = 1'b1;
                    bsy_wa = UW'(32'(r_p) + (32'd1 << (half - 5'(MIN_ORDER)))) & UMASK;
                    bsy_wd = 1'b0;
                    n_ord = half;
                    n_state = S_A_SPL2;
                end else begin
                    bsy_we = 1'b1; bsy_wa = r_p; bsy_wd = 1'b1;
                    n_status = ST_OK;
                    n_raddr_out = 16'(32'(r_p) << MIN_ORDER);
                    n_rorder = r_want;
                    n_valid = 1'b1; n_state = S_IDLE;
                end
            end
            S_A_SPL2: begin
                ord_we = 1'b1; ord_wa = r_q; ord_wd = r_ord;
                n_li = f_list(r_ord);
                n_x = r_p; n_ret = S_A_PUSHQ; n_state = S_P0;
            end
            S_A_PUSHQ: begin
                n_x = r_q; n_ret = S_A_UNL; n_state = S_P0;
            end
            S_A_UNL: begin
                n_x = r_p; n_ret = S_A_SPLIT; n_state = S_U0;
            end
            S_F_CHK: begin
                if (r_addr[MIN_ORDER-1:0] != '0 || u32 >= 32'(UNITS)) begin
                    n_status = ST_BAD_FREE; n_raddr_out = '0; n_rorder = '0;
                    n_valid = 1'b1; n_state = S_IDLE;
                end else begin
                    n_u = u32[UW-1:0] & UMASK;
                    ou_ra = u32[UW-1:0] & UMASK;
                    n_state = S_F_BSY;
                end
            end
            S_F_BSY: begin
                if (!bsy_q) begin
                    n_status = ST_BAD_FREE; n_raddr_out = '0; n_rorder = '0;
                    n_valid = 1'b1; n_state = S_IDLE;
                end else begin
                    bsy_we = 1'b1; bsy_wa = r_u; bsy_wd = 1'b0;
                    n_ord = ord_q;
                    n_state = S_F_LOOP;
                end
            end
            S_F_LOOP: begin
                if (r_ord >= 5'(TOP) || r_ord < 5'(MIN_ORDER)) begin
                    n_li = f_list(r_ord); n_x = r_u;
                    n_ret = S_F_DONE; n_state = S_P0;
                end else begin
                    tmp = (r_u ^ UW'(32'd1 << (r_ord - 5'(MIN_ORDER)))) & UMASK;
                    n_b = tmp; ou_ra = tmp;
                    n_state = S_F_BUD;
                end
            end
            S_F_BUD: begin
                n_li = f_list(r_ord);
                if (bsy_q || ord_q != r_ord) begin
                    n_x = r_u; n_ret = S_F_DONE; n_state = S_P0;
                end else begin
                    n_x = r_b; n_ret = S_F_MRG; n_state = S_U0;
                end
            end
            S_F_MRG: begin
                tmp = (r_b < r_u) ? r_b : r_u;
                n_u = tmp;
                ord_we = 1'b1; ord_wa = tmp; ord_wd = r_ord + 5'd1;
                n_ord = r_ord + 5'd1;
                n_state = S_F_LOOP;
            end
            S_F_DONE: begin
                n_status = ST_OK;
                n_raddr_out = 16'(32'(r_u) << MIN_ORDER);
                n_rorder = r_ord;
                n_valid = 1'b1; n_state = S_IDLE;
            end
            S_U0: begin
                nxt_ra = r_x; prv_ra = r_x;
                n_state = S_U1;
            end
            S_U1: begin
                // splice neighbors; successor becomes head unless block was alone
                prv_we = 1'b1; prv_wa = nxt_q & UMASK; prv_wd = prv_q & UMASK;
                nxt_we = 1'b1; nxt_wa = prv_q & UMASK; nxt_wd = nxt_q & UMASK;
                if ((prv_q & UMASK) == r_x) begin
                    n_vld[r_li] = 1'b0;
                end else begin
                    n_head[r_li] = nxt_q & UMASK;
                end
                n_state = r_ret;
            end
            S_P0: begin
                if (r_vld[r_li]) begin
                    n_h = r_head[r_li] & UMASK;
                    prv_ra = r_head[r_li] & UMASK;
                    n_state = S_P1;
                end else begin
                    nxt_we = 1'b1; nxt_wa = r_x; nxt_wd = r_x;
                    prv_we = 1'b1; prv_wa = r_x; prv_wd = r_x;
                    n_head[r_li] = r_x; n_vld[r_li] = 1'b1;
                    n_state = r_ret;
                end
            end
            S_P1: begin
                n_bk = prv_q & UMASK;
                prv_we = 1'b1; prv_wa = r_h; prv_wd = r_x;
                nxt_we = 1'b1; nxt_wa = prv_q & UMASK; nxt_wd = r_x;
                n_state = S_P2;
            end
            S_P2: begin
                nxt_we = 1'b1; nxt_wa = r_x; nxt_wd = r_h;
                prv_we = 1'b1; prv_wa = r_x; prv_wd = r_bk;
                n_head[r_li] = r_x; n_vld[r_li] = 1'b1;
                n_state = r_ret;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_result_address = r_raddr_out;
    assign o_result_order   = r_rorder;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still working");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_result_address == '0 && o_result_order == '0))
        else $error("failure result carries nonzero fields");
    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_result_order >= 5'(MIN_ORDER)))
        else $error("block order below minimum");

endmodule

FILE: tb/sv/tb_buddy_block_allocator_top.sv
module tb_buddy_block_allocator_top
    import bba_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUNITS = 2048;
    localparam int NORDERS = 12;
    localparam int LOW_ORD = 5;
    localparam int TOP_ORD = 16;
    localparam int HDR = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
        logic [4:0]  order;
    } t_alloc_result;

    class buddy_scoreboard;
        logic [10:0]   head[NORDERS];
        bit            head_ok[NORDERS];
        logic [4:0]    ord[NUNITS];
        bit            used[NUNITS];
        logic [10:0]   nxt[NUNITS];
        logic [10:0]   prv[NUNITS];
        t_alloc_result pending[$];
        int            errors;
        int            checked;

        function void clear();
            foreach (head[i]) begin
                head[i] = '0;
                head_ok[i] = 0;
            end
            foreach (ord[i]) begin
                ord[i] = '0;
                used[i] = 0;
                nxt[i] = '0;
                prv[i] = '0;
            end
            ord[0] = 5'(TOP_ORD);
            head_ok[NORDERS-1] = 1;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function int list_index(logic [10:0] u);
            int o;
            int li;
            o = ord[u];
            li = (o >= LOW_ORD) ? o - LOW_ORD : 0;
            return (li < NORDERS) ? li : NORDERS - 1;
        endfunction

        function void push_free(logic [10:0] u);
            int li;
            logic [10:0] h;
            logic [10:0] bk;
            li = list_index(u);
            if (head_ok[li]) begin
                h = head[li];
                bk = prv[h];
                prv[h] = u;
                nxt[bk] = u;
                nxt[u] = h;
                prv[u] = bk;
            end else begin
                nxt[u] = u;
                prv[u] = u;
            end
            head[li] = u;
            head_ok[li] = 1;
        endfunction

        function void pull_free(logic [10:0] u);
            int li;
            logic [10:0] bk;
            logic [10:0] fd;
            li = list_index(u);
            bk = prv[u];
            fd = nxt[u];
            prv[fd] = bk;
            nxt[bk] = fd;
            if (bk == u) head_ok[li] = 0;
            else head[li] = fd;
        endfunction

        function t_alloc_result note(logic cmd, logic [15:0] req, logic [15:0] addr);
            t_alloc_result r;
            int want;
            int nb;
            logic [10:0] p;
            logic [10:0] q;
            logic [10:0] b;
            int half;
            int o;
            r = '0;
            if (cmd == CMD_ALLOC) begin
                nb = int'(req) + HDR;
                want = LOW_ORD;
                while (want < 31 && (1 << want) < nb) want++;
                r.status = ST_NO_MEM;
                if (want <= TOP_ORD) begin
                    for (int i = want - LOW_ORD; i < NORDERS; i++) begin
                        if (head_ok[i]) begin
                            p = head[i];
                            pull_free(p);
                            while (int'(ord[p]) > want) begin
                                half = ord[p] - 1;
                                q = p + (11'd1 << (half - LOW_ORD));
                                ord[p] = 5'(half);
                                ord[q] = 5'(half);
                                used[q] = 0;
                                push_free(p);
                                push_free(q);
                                pull_free(p);
                            end
                            used[p] = 1;
                            r.status = ST_OK;
                            r.addr = {p, 5'd0};
                            r.order = 5'(want);
                            break;
                        end
                    end
                end
            end else begin
                p = addr[15:5];
                if (addr[4:0] != 0 || !used[p]) begin
                    r.status = ST_BAD_FREE;
                end else begin
                    used[p] = 0;
                    forever begin
                        o = ord[p];
                        if (o >= TOP_ORD || o < LOW_ORD) begin
                            push_free(p);
                            break;
                        end
                        b = p ^ (11'd1 << (o - LOW_ORD));
                        if (used[b] || int'(ord[b]) != o) begin
                            push_free(p);
                            break;
                        end
                        pull_free(b);
                        if (b < p) p = b;
                        ord[p] = 5'(o + 1);
                    end
                    r.addr = {p, 5'd0};
                    r.order = ord[p];
                end
            end
            pending.push_back(r);
            return r;
        endfunction

        function void check(logic [1:0] st, logic [15:0] ad, logic [4:0] od);
            t_alloc_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d addr=%h order=%0d",
                         $time, st, ad, od);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (ad !== e.addr) begin
                $display("%0t: address expected %h actual %h", $time, e.addr, ad);
                errors++;
            end
            if (od !== e.order) begin
                $display("%0t: order expected %0d actual %0d", $time, e.order, od);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_command;
    logic [15:0] i_request_bytes;
    logic [15:0] i_block_address;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_result_address;
    logic [4:0]  o_result_order;

    buddy_block_allocator_top dut (.*);

    buddy_scoreboard sb;
    logic [15:0] live[$];
    logic        busy_n = 1'b1;
    int          quiet_cycles = 0;
    int          n_alloc;
    int          n_free;
    bit          no_gaps;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Sample away from the active edge so nothing races with the block.
    always @(negedge i_clk) begin
        busy_n <= busy;
        if (i_rst_n && o_valid) sb.check(o_status, o_result_address, o_result_order);
    end

    always @(posedge i_clk) begin
        if ((start && !busy_n) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("tb_buddy_block_allocator_top: errors");
            $finish;
        end
    end

    task automatic send(logic cmd, logic [15:0] req, logic [15:0] addr);
        t_alloc_result r;
        start <= 1'b1;
        i_command <= cmd;
        i_request_bytes <= req;
        i_block_address <= addr;
        do @(posedge i_clk); while (!(start && !busy_n));
        r = sb.note(cmd, req, addr);
        if (cmd == CMD_ALLOC) begin
            n_alloc++;
            if (r.status == ST_OK) live.push_back(r.addr);
        end else begin
            n_free++;
        end
        if (!no_gaps && $urandom_range(0, 99) < 38) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic free_live(int idx);
        logic [15:0] a;
        a = live[idx];
        live.delete(idx);
        send(~CMD_ALLOC, 16'($urandom), a);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] r16;
        int pick;
        sb = new();
        sb.clear();
        start = 1'b0;
        i_command = 1'b0;
        i_request_bytes = '0;
        i_block_address = '0;
        n_alloc = 0;
        n_free = 0;
        no_gaps = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sizes at order edges, oversize, bad frees, full merge
        send(CMD_ALLOC, 16'd0, 16'hFFFF);
        send(CMD_ALLOC, 16'd16, 16'd0);
        send(CMD_ALLOC, 16'd17, 16'd0);
        send(CMD_ALLOC, 16'd65535, 16'd0);
        send(CMD_ALLOC, 16'd65520, 16'd0);
        send(CMD_ALLOC, 16'd32752, 16'd0);
        send(~CMD_ALLOC, 16'd0, 16'd1);
        send(~CMD_ALLOC, 16'd0, 16'hFFFF);
        send(~CMD_ALLOC, 16'd0, 16'hFFE0);
        send(~CMD_ALLOC, 16'hFFFF, 16'd16);
        while (live.size() != 0) free_live(0);
        send(~CMD_ALLOC, 16'd0, 16'd0);
        send(CMD_ALLOC, 16'd65520, 16'd0);
        send(CMD_ALLOC, 16'd0, 16'd0);
        free_live(0);
        send(CMD_ALLOC, 16'd1000, 16'd0);
        send(CMD_ALLOC, 16'd0, 16'd0);
        free_live(1);
        free_live(0);

        for (int n = 0; n < 500; n++) begin
            no_gaps = (n >= 200 && n < 300);
            if (n == 320) drain();
            pick = $urandom_range(0, 99);
            if (pick < 48 || (live.size() == 0 && pick < 90)) begin
                case ($urandom_range(0, 9))
                    0:       r16 = 16'($urandom);
                    1, 2:    r16 = 16'($urandom_range(0, 8000));
                    default: r16 = 16'($urandom_range(0, 300));
                endcase
                send(CMD_ALLOC, r16, 16'($urandom));
            end else if (pick < 90) begin
                free_live($urandom_range(0, live.size() - 1));
            end else begin
                r16 = 16'($urandom);
                if ($urandom_range(0, 1)) r16[4:0] = '0;
                send(~CMD_ALLOC, 16'($urandom), r16);
            end
        end
        while (live.size() != 0) free_live(0);

        drain();
        repeat (200) @(posedge i_clk);
        $display("ran %0d allocates and %0d frees, %0d results checked",
                 n_alloc, n_free, sb.checked);
        $display("covered splits, buddy merges, out-of-memory and bad frees");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_buddy_block_allocator_top: clean");
        end else begin
            $display("tb_buddy_block_allocator_top: errors");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/buddy_block_allocator_top.sv
tb/sv/tb_buddy_block_allocator_top.sv
